// ===== rtl/core/pbt_pkg.sv =====
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types, widths and constants of the power budget throttle
// ----------------------------------------------------------------------------
package pbt_pkg;

	// window geometry
	localparam int WINDOW_LEN = 5;
	localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W      = (SLOT_W > 3) ? SLOT_W : 3;

	// field widths
	localparam int LIMIT_W   = 18;
	localparam int VBUS_W    = 15;
	localparam int IMA_W     = 15;
	localparam int GAIN_W    = 16;
	localparam int READING_W = 21;
	localparam int PROD_W    = VBUS_W + IMA_W;
	localparam int NUM_THR   = 5;
	localparam int MASK_W    = NUM_THR;
	localparam int GAP_W     = 23;
	localparam int SUM_W     = READING_W + $clog2(WINDOW_LEN) + 1;

	// mW = mV * mA / 1000, by reciprocal multiply and one correction step
	localparam int MW_DIV      = 1000;
	localparam int DIV_K       = 40;
	localparam int DIV_RECIP_W = 31;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
		DIV_RECIP_W'((64'd1 << DIV_K) / MW_DIV);
	localparam int REM_W       = PROD_W + 1;

	// window average, same scheme
	localparam int AVG_K       = SUM_W;
	localparam int AVG_RECIP_W = SUM_W + 1;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
		AVG_RECIP_W'((64'd1 << AVG_K) / WINDOW_LEN);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAIN_W;
	localparam logic [GAIN_W-1:0] GAIN_TYPE_A_RST = GAIN_W'(3200);
	localparam logic [GAIN_W-1:0] GAIN_TYPE_C_RST = GAIN_W'(8800);

	typedef logic [SLOT_W-1:0] slot_t;
	localparam slot_t LAST_SLOT = slot_t'(WINDOW_LEN - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_A = 1'b0,
		CFG_GAIN_C = 1'b1
	} cfg_idx_t;

	// throttle positions, in priority order
	typedef enum logic [2:0] {
		T_REAR    = 3'd0,
		T_FRONT   = 3'd1,
		T_C0      = 3'd2,
		T_C1      = 3'd3,
		T_PROCHOT = 3'd4
	} thr_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RECIP,
		S_CORR,
		S_SCAN,
		S_AVG_MUL,
		S_AVG_CORR,
		S_CHAIN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic                 system_off;
		logic [LIMIT_W-1:0]   charger_limit_mw;
		logic [VBUS_W-1:0]    vbus_mv;
		logic [IMA_W-1:0]     input_ma;
		logic                 supplier_is_pd;
		logic                 c0_sourcing;
		logic                 c1_sourcing;
	} tick_t;

	typedef struct packed {
		logic                limit_rear_a;
		logic                limit_front_a;
		logic                limit_c0;
		logic                limit_c1;
		logic                prochot_on;
		logic [MASK_W-1:0]   changed_mask;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     recip;
		logic     corr;
		logic     scan;
		logic     avg_mul;
		logic     avg_corr;
		logic     chain;
		logic     result;
		slot_t    slot;
		thr_idx_t stage;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic quick;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/pbt_tick_if.sv =====
// ----------------------------------------------------------------------------
// pbt_tick_if
// Monitoring tick channel: valid/ready handshake with the tick fields
// ----------------------------------------------------------------------------
interface pbt_tick_if;

	logic                          valid;
	logic                          ready;
	logic                          system_off;
	logic [pbt_pkg::LIMIT_W-1:0]   charger_limit_mw;
	logic [pbt_pkg::VBUS_W-1:0]    vbus_mv;
	logic [pbt_pkg::IMA_W-1:0]     input_ma;
	logic                          supplier_is_pd;
	logic                          c0_sourcing;
	logic                          c1_sourcing;

	modport source (
		output valid, system_off, charger_limit_mw, vbus_mv, input_ma,
		       supplier_is_pd, c0_sourcing, c1_sourcing,
		input  ready
	);

	modport sink (
		input  valid, system_off, charger_limit_mw, vbus_mv, input_ma,
		       supplier_is_pd, c0_sourcing, c1_sourcing,
		output ready
	);

endinterface

// ===== rtl/core/pbt_result_if.sv =====
// ----------------------------------------------------------------------------
// pbt_result_if
// Throttle result channel: valid/ready handshake with the result fields
// ----------------------------------------------------------------------------
interface pbt_result_if;

	logic                         valid;
	logic                         ready;
	logic                         limit_rear_a;
	logic                         limit_front_a;
	logic                         limit_c0;
	logic                         limit_c1;
	logic                         prochot_on;
	logic [pbt_pkg::MASK_W-1:0]   changed_mask;

	modport source (
		output valid, limit_rear_a, limit_front_a, limit_c0, limit_c1,
		       prochot_on, changed_mask,
		input  ready
	);

	modport sink (
		input  valid, limit_rear_a, limit_front_a, limit_c0, limit_c1,
		       prochot_on, changed_mask,
		output ready
	);

endinterface

// ===== rtl/core/pbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbt_ctrl
// Sequencer: steps one request through power, window scan, average and the
// throttle priority chain, and issues datapath commands
// ----------------------------------------------------------------------------
module pbt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	input  pbt_pkg::status_t  status,
	output logic              tick_ready,
	output pbt_pkg::cmd_t     cmd
);

	pbt_pkg::state_t            state_q;
	pbt_pkg::state_t            state_d;
	logic [pbt_pkg::CNT_W-1:0]  cnt_q;
	pbt_pkg::slot_t             cur_slot;
	pbt_pkg::thr_idx_t          cur_stage;

	assign cur_slot  = cnt_q[pbt_pkg::SLOT_W-1:0];
	assign cur_stage = pbt_pkg::thr_idx_t'(cnt_q[2:0]);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step counter for the window scan and the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == pbt_pkg::S_CORR || state_q == pbt_pkg::S_AVG_CORR) begin
			cnt_q <= '0;
		end else if (state_q == pbt_pkg::S_SCAN || state_q == pbt_pkg::S_CHAIN) begin
			cnt_q <= cnt_q + pbt_pkg::CNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbt_pkg::S_IDLE: begin
				if (tick_valid) begin
					state_d = status.quick ? pbt_pkg::S_RESULT : pbt_pkg::S_RECIP;
				end
			end
			pbt_pkg::S_RECIP:    state_d = pbt_pkg::S_CORR;
			pbt_pkg::S_CORR:     state_d = pbt_pkg::S_SCAN;
			pbt_pkg::S_SCAN: begin
				if (cur_slot == pbt_pkg::LAST_SLOT) begin
					state_d = pbt_pkg::S_AVG_MUL;
				end
			end
			pbt_pkg::S_AVG_MUL:  state_d = pbt_pkg::S_AVG_CORR;
			pbt_pkg::S_AVG_CORR: state_d = pbt_pkg::S_CHAIN;
			pbt_pkg::S_CHAIN: begin
				if (cur_stage == pbt_pkg::T_PROCHOT) begin
					state_d = pbt_pkg::S_RESULT;
				end
			end
			pbt_pkg::S_RESULT: begin
				if (status.out_free) begin
					state_d = pbt_pkg::S_IDLE;
				end
			end
			default:             state_d = pbt_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		cmd.slot   = cur_slot;
		cmd.stage  = cur_stage;
		tick_ready = 1'b0;
		unique case (state_q)
			pbt_pkg::S_IDLE: begin
				tick_ready = 1'b1;
				cmd.load   = tick_valid;
			end
			pbt_pkg::S_RECIP:    cmd.recip    = 1'b1;
			pbt_pkg::S_CORR:     cmd.corr     = 1'b1;
			pbt_pkg::S_SCAN:     cmd.scan     = 1'b1;
			pbt_pkg::S_AVG_MUL:  cmd.avg_mul  = 1'b1;
			pbt_pkg::S_AVG_CORR: cmd.avg_corr = 1'b1;
			pbt_pkg::S_CHAIN:    cmd.chain    = 1'b1;
			pbt_pkg::S_RESULT:   cmd.result   = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/pbt_datapath.sv =====
// ----------------------------------------------------------------------------
// pbt_datapath
// Power computation, reading window, average/peak, gap and throttle chain,
// plus the throttle state and the result output register
// ----------------------------------------------------------------------------
module pbt_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pbt_pkg::cmd_t                cmd,
	input  pbt_pkg::tick_t               tick,
	input  logic [pbt_pkg::GAIN_W-1:0]   gain_a,
	input  logic [pbt_pkg::GAIN_W-1:0]   gain_c,
	input  logic                         out_ready,
	output pbt_pkg::status_t             status,
	output pbt_pkg::result_t             res,
	output logic                         out_valid
);

	// state
	logic [pbt_pkg::READING_W-1:0]   win_q [pbt_pkg::WINDOW_LEN];
	pbt_pkg::slot_t                  write_slot_q;
	logic [pbt_pkg::NUM_THR-1:0]     throttle_q;
	logic                            out_valid_q;

	// per-request working registers
	logic [pbt_pkg::PROD_W-1:0]      prod_q;
	logic [pbt_pkg::READING_W-1:0]   pow_q0_q;
	logic [pbt_pkg::LIMIT_W-1:0]     limit_q;
	logic                            is_pd_q;
	logic                            c0_q;
	logic                            c1_q;
	logic [pbt_pkg::SUM_W-1:0]       sum_q;
	logic [pbt_pkg::READING_W-1:0]   peak_q;
	logic [pbt_pkg::READING_W-1:0]   avg_q0_q;
	logic signed [pbt_pkg::GAP_W-1:0] gap_q;
	logic [pbt_pkg::NUM_THR-1:0]     next_q;
	pbt_pkg::result_t                res_q;

	// combinational
	logic [pbt_pkg::PROD_W+pbt_pkg::DIV_RECIP_W-1:0]   pow_mul;
	logic [pbt_pkg::REM_W-1:0]                         pow_rem;
	logic [pbt_pkg::READING_W-1:0]                     power;
	logic                                              refill;
	pbt_pkg::slot_t                                    slot_cur;
	logic [pbt_pkg::READING_W-1:0]                     rd;
	logic [pbt_pkg::SUM_W+pbt_pkg::AVG_RECIP_W-1:0]    avg_mul;
	logic [pbt_pkg::SUM_W-1:0]                         avg_rem;
	logic [pbt_pkg::READING_W-1:0]                     avg;
	logic [pbt_pkg::READING_W-1:0]                     sel_pow;
	logic signed [pbt_pkg::GAP_W-1:0]                  gap_new;
	logic                                              stage_en;
	logic [pbt_pkg::GAIN_W-1:0]                        stage_gain;
	logic                                              gap_le0;

	// handshake status
	assign status.quick    = tick.system_off || (tick.charger_limit_mw == '0);
	assign status.out_free = !out_valid_q || out_ready;

	// power = product / 1000: estimate, then one correction step
	assign pow_mul = prod_q * pbt_pkg::DIV_RECIP;
	assign pow_rem = pbt_pkg::REM_W'(prod_q)
		- pbt_pkg::REM_W'(pow_q0_q * pbt_pkg::MW_DIV);
	assign power   = (pow_rem >= pbt_pkg::REM_W'(pbt_pkg::MW_DIV))
		? pow_q0_q + pbt_pkg::READING_W'(1) : pow_q0_q;

	// window write position and refill when the first slot is empty
	assign refill   = (win_q[0] == '0);
	assign slot_cur = (write_slot_q <= pbt_pkg::LAST_SLOT) ? write_slot_q : '0;

	// scan read port
	assign rd = win_q[cmd.slot];

	// average = sum / window length, same correction scheme
	assign avg_mul = sum_q * pbt_pkg::AVG_RECIP;
	assign avg_rem = sum_q - pbt_pkg::SUM_W'(avg_q0_q * pbt_pkg::WINDOW_LEN);
	assign avg     = (avg_rem >= pbt_pkg::SUM_W'(pbt_pkg::WINDOW_LEN))
		? avg_q0_q + pbt_pkg::READING_W'(1) : avg_q0_q;

	// gap = limit - selected power
	assign sel_pow = is_pd_q ? peak_q : avg;
	assign gap_new = $signed({{(pbt_pkg::GAP_W-pbt_pkg::LIMIT_W){1'b0}}, limit_q})
		- $signed({{(pbt_pkg::GAP_W-pbt_pkg::READING_W){1'b0}}, sel_pow});

	// current chain stage
	always_comb begin
		unique case (cmd.stage)
			pbt_pkg::T_REAR, pbt_pkg::T_FRONT: begin
				stage_en   = 1'b1;
				stage_gain = gain_a;
			end
			pbt_pkg::T_C0: begin
				stage_en   = c0_q;
				stage_gain = gain_c;
			end
			pbt_pkg::T_C1: begin
				stage_en   = c1_q;
				stage_gain = gain_c;
			end
			pbt_pkg::T_PROCHOT: begin
				stage_en   = 1'b1;
				stage_gain = '0;
			end
			default: begin
				stage_en   = 1'b0;
				stage_gain = '0;
			end
		endcase
	end

	assign gap_le0 = gap_q[pbt_pkg::GAP_W-1] || (gap_q == '0);

	// window, write slot, throttle state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pbt_pkg::WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			write_slot_q <= '0;
			throttle_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load && tick.system_off) begin
				win_q[0] <= '0;
			end
			if (cmd.corr) begin
				for (int i = 0; i < pbt_pkg::WINDOW_LEN; i++) begin
					if (refill || (slot_cur == pbt_pkg::slot_t'(i))) begin
						win_q[i] <= power;
					end
				end
				write_slot_q <= (slot_cur == pbt_pkg::LAST_SLOT)
					? '0 : slot_cur + pbt_pkg::SLOT_W'(1);
			end
			if (cmd.result) begin
				throttle_q  <= next_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q  <= tick.vbus_mv * tick.input_ma;
			limit_q <= tick.charger_limit_mw;
			is_pd_q <= tick.supplier_is_pd;
			c0_q    <= tick.c0_sourcing;
			c1_q    <= tick.c1_sourcing;
			next_q  <= '0;
		end
		if (cmd.recip) begin
			pow_q0_q <= pow_mul[pbt_pkg::DIV_K +: pbt_pkg::READING_W];
		end
		if (cmd.scan) begin
			if (cmd.slot == '0) begin
				sum_q  <= pbt_pkg::SUM_W'(rd);
				peak_q <= rd;
			end else begin
				sum_q  <= sum_q + pbt_pkg::SUM_W'(rd);
				peak_q <= (rd > peak_q) ? rd : peak_q;
			end
		end
		if (cmd.avg_mul) begin
			avg_q0_q <= avg_mul[pbt_pkg::AVG_K +: pbt_pkg::READING_W];
		end
		if (cmd.avg_corr) begin
			gap_q <= gap_new;
		end
		if (cmd.chain && stage_en && gap_le0) begin
			next_q[cmd.stage] <= 1'b1;
			if (!throttle_q[cmd.stage]) begin
				gap_q <= gap_q + $signed({{(pbt_pkg::GAP_W-pbt_pkg::GAIN_W){1'b0}},
					stage_gain});
			end
		end
		if (cmd.result) begin
			res_q.limit_rear_a  <= next_q[pbt_pkg::T_REAR];
			res_q.limit_front_a <= next_q[pbt_pkg::T_FRONT];
			res_q.limit_c0      <= next_q[pbt_pkg::T_C0];
			res_q.limit_c1      <= next_q[pbt_pkg::T_C1];
			res_q.prochot_on    <= next_q[pbt_pkg::T_PROCHOT];
			res_q.changed_mask  <= next_q ^ throttle_q;
		end
	end

	assign res       = res_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// write slot never leaves the window
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q <= pbt_pkg::LAST_SLOT)
		else $error("write slot out of range");

	// reciprocal estimate is at most one below the true quotient
	a_pow_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.corr |-> (pow_rem < pbt_pkg::REM_W'(2 * pbt_pkg::MW_DIV)))
		else $error("power quotient estimate off by more than one");

	a_avg_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_corr |-> (avg_rem < pbt_pkg::SUM_W'(2 * pbt_pkg::WINDOW_LEN)))
		else $error("average quotient estimate off by more than one");

	// a loaded result is presented with the mask of the old state
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |=> out_valid_q
			&& (res_q.changed_mask == $past(next_q ^ throttle_q)))
		else $error("result not presented or mask wrong");
`endif

endmodule

// ===== rtl/core/power_budget_throttle.sv =====
// ----------------------------------------------------------------------------
// power_budget_throttle - throttle priority chain on a windowed power budget
// Steps: tick accept, power estimate and correction, window scan, average and
//   its correction, throttle chain, result; off or zero-limit ticks skip to the
//   result, which waits for a free output. One request in flight at a time
// Reset: async active low; window, write slot, throttles clear, gains to default
// ----------------------------------------------------------------------------
module power_budget_throttle (
	input  logic                             clk,
	input  logic                             arst_n,
	pbt_tick_if.sink                         tick,
	pbt_result_if.source                     res,
	input  logic                             cfg_we,
	input  logic [pbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [pbt_pkg::GAIN_W-1:0]   gain_a_q;
	logic [pbt_pkg::GAIN_W-1:0]   gain_c_q;
	pbt_pkg::cmd_t                cmd;
	pbt_pkg::status_t             status;
	pbt_pkg::tick_t               tick_pl;
	pbt_pkg::result_t             res_pl;
	logic                         out_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_a_q <= pbt_pkg::GAIN_TYPE_A_RST;
			gain_c_q <= pbt_pkg::GAIN_TYPE_C_RST;
		end else if (cfg_we) begin
			unique case (pbt_pkg::cfg_idx_t'(cfg_index))
				pbt_pkg::CFG_GAIN_A: gain_a_q <= cfg_data;
				pbt_pkg::CFG_GAIN_C: gain_c_q <= cfg_data;
			endcase
		end
	end

	// pack the tick request
	assign tick_pl.system_off       = tick.system_off;
	assign tick_pl.charger_limit_mw = tick.charger_limit_mw;
	assign tick_pl.vbus_mv          = tick.vbus_mv;
	assign tick_pl.input_ma         = tick.input_ma;
	assign tick_pl.supplier_is_pd   = tick.supplier_is_pd;
	assign tick_pl.c0_sourcing      = tick.c0_sourcing;
	assign tick_pl.c1_sourcing      = tick.c1_sourcing;

	pbt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.status     (status),
		.tick_ready (tick.ready),
		.cmd        (cmd)
	);

	pbt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tick      (tick_pl),
		.gain_a    (gain_a_q),
		.gain_c    (gain_c_q),
		.out_ready (res.ready),
		.status    (status),
		.res       (res_pl),
		.out_valid (out_valid)
	);

	// unpack the result request
	assign res.valid         = out_valid;
	assign res.limit_rear_a  = res_pl.limit_rear_a;
	assign res.limit_front_a = res_pl.limit_front_a;
	assign res.limit_c0      = res_pl.limit_c0;
	assign res.limit_c1      = res_pl.limit_c1;
	assign res.prochot_on    = res_pl.prochot_on;
	assign res.changed_mask  = res_pl.changed_mask;

endmodule
